// File: src/svm_exec_pkg.sv
// ============================================================================
// svm_exec_pkg
// shared types and constants of the stack machine integer execute core
// ============================================================================
`default_nettype none

package svm_exec_pkg;

    // input word layout, lowest bit first
    localparam int IN_W        = 64;
    localparam int IN_OP_LSB   = 0;
    localparam int IN_OP_W     = 5;
    localparam int IN_RD_LSB   = 5;
    localparam int IN_RS_LSB   = 7;
    localparam int IN_REG_W    = 2;
    localparam int IN_IMM_LSB  = 9;
    localparam int IN_TGT_LSB  = 41;
    localparam int TGT_W       = 16;

    // output word width, data width and register count
    localparam int OUT_W       = 56;
    localparam int DATA_W      = 32;
    localparam int NUM_REGS    = 4;

    // flag bit positions
    localparam int FLAG_Z      = 0;
    localparam int FLAG_S      = 1;
    localparam int FLAG_C      = 2;
    localparam int FLAG_O      = 3;

    typedef enum logic [4:0] {
        OP_PUSHC  = 5'd0,
        OP_PUSHR  = 5'd1,
        OP_MOVRR  = 5'd2,
        OP_MOVRC  = 5'd3,
        OP_POPR   = 5'd4,
        OP_ADD    = 5'd5,
        OP_SUB    = 5'd6,
        OP_MUL    = 5'd7,
        OP_CMP    = 5'd8,
        OP_JMP    = 5'd9,
        OP_JZ     = 5'd10,
        OP_JNZ    = 5'd11,
        OP_JG     = 5'd12,
        OP_JGE    = 5'd13,
        OP_JL     = 5'd14,
        OP_JLE    = 5'd15,
        OP_OUTINT = 5'd16,
        OP_OUTCH  = 5'd17
    } op_t;

    typedef enum logic [1:0] {
        FAULT_NONE  = 2'd0,
        FAULT_OVER  = 2'd1,
        FAULT_UNDER = 2'd2
    } fault_t;

endpackage

`default_nettype wire

// File: src/svm_exec_ram.sv
// ============================================================================
// svm_exec_ram
// generic single write port, single read port ram with registered read
// ============================================================================
`default_nettype none

module svm_exec_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  wire logic                     clk,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]         wr_data,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic      [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end

endmodule

`default_nettype wire

// File: src/stack_vm_integer_execute_core.sv
// ============================================================================
// stack_vm_integer_execute_core
// executes one decoded integer instruction of a small stack machine per word
// ============================================================================
// usage
// - s_* channel takes one decoded instruction per word, m_* channel returns
//   one result word per instruction, in order
// - an accepted word is held in the input register, then all of its work
//   (register file, stack top, flags, pc, one 32x32 multiply) is done in
//   one pass and written into the result register that drives m_tvalid
// - throughput is one word per clock while m_tready stays high; the state
//   (registers, stack, flags, pc) is updated at the moment a word moves
//   into the result register, so the next instruction sees it with no gap
// - the stack top lives in a register; entries below it are in a ram whose
//   registered read is always aimed at the entry under the top, so a pop
//   has its new top ready in the next cycle
// - when m_tready is low the result register holds, the input register
//   fills, and then s_tready drops; nothing is lost or repeated
// - reset clears registers, flags, pc, stack count and both valid flags;
//   stack contents are undefined until pushed
// - a push onto a full stack or a pop or output on an empty stack returns a
//   fault code and leaves all state, including the pc, unchanged
// ============================================================================
`default_nettype none

module stack_vm_integer_execute_core
    import svm_exec_pkg::*;
#(
    parameter int STACK_DEPTH = 16,
    parameter int PC_BITS     = 16
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    // instruction words
    input  wire logic             s_tvalid,
    output logic                  s_tready,
    // req_type[4:0], dest_reg[6:5], src_reg[8:7], immediate[40:9],
    // jump_target[56:41], zero[63:57]
    input  wire logic [IN_W-1:0]  s_tdata,
    // result words
    output logic                  m_tvalid,
    input  wire logic             m_tready,
    // next_pc[15:0], out_valid[16], out_value[48:17], zero_flag[49],
    // sign_flag[50], carry_flag[51], overflow_flag[52], fault[54:53],
    // zero[55]
    output logic [OUT_W-1:0]      m_tdata
);

    localparam int AW = $clog2(STACK_DEPTH);
    localparam int CW = $clog2(STACK_DEPTH + 1);

    // input stage
    logic                in_valid_reg;
    logic [IN_OP_W-1:0]  op_reg;
    logic [IN_REG_W-1:0] rd_reg;
    logic [IN_REG_W-1:0] rs_reg;
    logic [DATA_W-1:0]   imm_reg;
    logic [TGT_W-1:0]    tgt_reg;

    // result stage
    logic                out_valid_reg;
    logic [OUT_W-1:0]    out_data_reg;

    // machine state
    logic [DATA_W-1:0]   gp_reg [NUM_REGS];
    logic [DATA_W-1:0]   gp_next [NUM_REGS];
    logic [CW-1:0]       count_reg;
    logic [CW-1:0]       count_next;
    logic [PC_BITS-1:0]  pc_reg;
    logic [PC_BITS-1:0]  pc_next;
    logic [3:0]          flags_reg;
    logic [3:0]          flags_next;
    logic [DATA_W-1:0]   top_reg;
    logic [DATA_W-1:0]   top_next;

    // entry under the top: either the ram read or the old top after a push
    logic                below_sel_reg;
    logic                below_sel_next;
    logic [DATA_W-1:0]   below_hold_reg;
    logic [DATA_W-1:0]   below_hold_next;
    logic [DATA_W-1:0]   ram_rdata;
    logic [DATA_W-1:0]   below;

    logic                advance;
    op_t                 op;
    logic [DATA_W-1:0]   a_val;
    logic [DATA_W-1:0]   b_val;
    logic [DATA_W-1:0]   diff;
    logic [DATA_W-1:0]   prod;
    logic                z_f;
    logic                s_f;
    logic                o_f;
    logic                taken;
    logic [PC_BITS-1:0]  target;
    logic                emit;
    logic [DATA_W-1:0]   value;
    fault_t              fault;
    logic                ram_wr_en;
    logic [CW-1:0]       count_m1;
    logic [CW-1:0]       rd_count;
    logic [CW-1:0]       rd_count_m2;
    logic [AW-1:0]       ram_rd_addr;
    logic [OUT_W-1:0]    result;

    // handshake: result register moves on when empty or taken
    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

    assign op     = op_t'(op_reg);
    assign a_val  = gp_reg[rd_reg];
    assign b_val  = gp_reg[rs_reg];
    assign diff   = a_val - b_val;
    assign prod   = a_val * b_val;
    assign z_f    = flags_reg[FLAG_Z];
    assign s_f    = flags_reg[FLAG_S];
    assign o_f    = flags_reg[FLAG_O];
    assign target = PC_BITS'(tgt_reg);
    assign below  = below_sel_reg ? below_hold_reg : ram_rdata;

    assign count_m1 = count_reg - CW'(1);

    always_comb
    begin
        gp_next         = gp_reg;
        count_next      = count_reg;
        flags_next      = flags_reg;
        top_next        = top_reg;
        below_sel_next  = below_sel_reg;
        below_hold_next = below_hold_reg;
        pc_next         = pc_reg + PC_BITS'(1);
        taken           = 1'b0;
        emit            = 1'b0;
        value           = '0;
        fault           = FAULT_NONE;
        ram_wr_en       = 1'b0;

        case (op)
            OP_PUSHC, OP_PUSHR:
            begin
                if (count_reg == CW'(STACK_DEPTH))
                begin
                    fault = FAULT_OVER;
                end
                else
                begin
                    // old top goes down into the ram
                    ram_wr_en       = (count_reg != '0);
                    top_next        = (op == OP_PUSHC) ? imm_reg : a_val;
                    below_sel_next  = 1'b1;
                    below_hold_next = top_reg;
                    count_next      = count_reg + CW'(1);
                end
            end
            OP_MOVRR: gp_next[rd_reg] = b_val;
            OP_MOVRC: gp_next[rd_reg] = imm_reg;
            OP_POPR:
            begin
                if (count_reg == '0)
                begin
                    fault = FAULT_UNDER;
                end
                else
                begin
                    gp_next[rd_reg] = top_reg;
                    top_next        = below;
                    below_sel_next  = 1'b0;
                    count_next      = count_m1;
                end
            end
            OP_ADD: gp_next[rd_reg] = a_val + b_val;
            OP_SUB: gp_next[rd_reg] = diff;
            OP_MUL: gp_next[rd_reg] = prod;
            OP_CMP:
            begin
                flags_next[FLAG_Z] = (diff == '0);
                flags_next[FLAG_S] = diff[DATA_W-1];
                flags_next[FLAG_C] = (a_val < b_val);
                flags_next[FLAG_O] = (a_val[DATA_W-1] != b_val[DATA_W-1])
                                  && (diff[DATA_W-1] != a_val[DATA_W-1]);
            end
            OP_JMP, OP_JZ, OP_JNZ, OP_JG, OP_JGE, OP_JL, OP_JLE:
            begin
                case (op)
                    OP_JMP:  taken = 1'b1;
                    OP_JZ:   taken = z_f;
                    OP_JNZ:  taken = !z_f;
                    OP_JG:   taken = !z_f && (s_f == o_f);
                    OP_JGE:  taken = (s_f == o_f);
                    OP_JL:   taken = (s_f != o_f);
                    default: taken = z_f || (s_f != o_f);
                endcase
                if (taken)
                begin
                    pc_next = target;
                end
            end
            OP_OUTINT, OP_OUTCH:
            begin
                if (count_reg == '0)
                begin
                    fault = FAULT_UNDER;
                end
                else
                begin
                    emit  = 1'b1;
                    value = (op == OP_OUTCH) ? {24'd0, top_reg[7:0]} : top_reg;
                end
            end
            default:
            begin
                // unused codes do nothing but advance the pc
            end
        endcase

        if (fault != FAULT_NONE)
        begin
            pc_next = pc_reg;
        end
    end

    // ram read always aims at the entry under the (next) top
    assign rd_count    = advance ? count_next : count_reg;
    assign rd_count_m2 = rd_count - CW'(2);
    assign ram_rd_addr = (rd_count >= CW'(2)) ? rd_count_m2[AW-1:0] : '0;

    svm_exec_ram #(
        .WIDTH (DATA_W),
        .DEPTH (STACK_DEPTH)
    ) u_stack_ram (
        .clk     (clk),
        .wr_en   (advance && ram_wr_en),
        .wr_addr (count_m1[AW-1:0]),
        .wr_data (top_reg),
        .rd_addr (ram_rd_addr),
        .rd_data (ram_rdata)
    );

    assign result = {1'b0, fault, flags_next[FLAG_O], flags_next[FLAG_C],
                     flags_next[FLAG_S], flags_next[FLAG_Z], value, emit,
                     16'(pc_next)};

    // control and machine state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            count_reg     <= '0;
            pc_reg        <= '0;
            flags_reg     <= '0;
            below_sel_reg <= 1'b0;
            for (int i = 0; i < NUM_REGS; i++)
            begin
                gp_reg[i] <= '0;
            end
        end
        else
        begin
            if (s_tready)
            begin
                in_valid_reg <= s_tvalid;
            end
            if (advance)
            begin
                out_valid_reg <= 1'b1;
                count_reg     <= count_next;
                pc_reg        <= pc_next;
                flags_reg     <= flags_next;
                below_sel_reg <= below_sel_next;
                gp_reg        <= gp_next;
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
        begin
            op_reg  <= s_tdata[IN_OP_LSB +: IN_OP_W];
            rd_reg  <= s_tdata[IN_RD_LSB +: IN_REG_W];
            rs_reg  <= s_tdata[IN_RS_LSB +: IN_REG_W];
            imm_reg <= s_tdata[IN_IMM_LSB +: DATA_W];
            tgt_reg <= s_tdata[IN_TGT_LSB +: TGT_W];
        end
        if (advance)
        begin
            out_data_reg   <= result;
            top_reg        <= top_next;
            below_hold_reg <= below_hold_next;
        end
    end

    // stack count never passes the depth
    assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(STACK_DEPTH))
        else $error("stack count beyond depth");

    // a faulting instruction leaves stack and pc untouched
    assert property (@(posedge clk) disable iff (!rst_n)
        advance && (fault != FAULT_NONE) |=> $stable(count_reg) && $stable(pc_reg))
        else $error("state changed on fault");

    // state only moves when an instruction retires
    assert property (@(posedge clk) disable iff (!rst_n)
        !advance |=> $stable(count_reg) && $stable(pc_reg) && $stable(flags_reg))
        else $error("state changed without an instruction");

    // an emitted value always comes from a non-empty stack
    assert property (@(posedge clk) disable iff (!rst_n)
        advance && emit |-> (count_reg != '0) && (fault == FAULT_NONE))
        else $error("output from empty stack");

endmodule

`default_nettype wire

// File: tb/stack_vm_integer_execute_core_tb.sv
// ============================================================================
// stack_vm_integer_execute_core_tb
// self-checking bench for the stack machine integer execute core
// ============================================================================
// instruction words go in through the s_* stream, one result word per
// instruction comes back on m_*; a behavioral copy of the machine (registers,
// stack, pc, flags) predicts every result at the moment its instruction is
// taken, and the checker compares each result word field by field in order.
// named tests cover empty-stack faults, compare and all jumps, wrapping
// arithmetic, stack output, unused codes, full-stack bursts, random programs,
// raw noise and a stretch with no idling on either side
// ============================================================================
`timescale 1ns / 100ps
`default_nettype none

module stack_vm_integer_execute_core_tb;

    import svm_exec_pkg::*;

    localparam int STACK_SLOTS = 16;
    localparam int CYCLE_LIMIT = 200000;

    // one predicted result word
    typedef struct {
        logic [15:0] next_pc;
        logic        out_valid;
        logic [31:0] out_value;
        logic        zero;
        logic        sign;
        logic        carry;
        logic        ovfl;
        fault_t      fault;
    } retire_t;

    logic            clk = 1'b0;
    logic            rst_n = 1'b0;
    logic            s_tvalid = 1'b0;
    logic            s_tready;
    logic [IN_W-1:0] s_tdata = '0;
    logic            m_tvalid;
    logic            m_tready = 1'b1;
    logic [OUT_W-1:0] m_tdata;

    // machine state as the bench sees it
    logic [31:0] vm_regs [NUM_REGS];
    logic [31:0] vm_stack [STACK_SLOTS];
    int          stack_depth = 0;
    logic [15:0] vm_pc = '0;
    logic        z_flag = 1'b0;
    logic        s_flag = 1'b0;
    logic        c_flag = 1'b0;
    logic        v_flag = 1'b0;

    retire_t     retire_q [$];

    int gap_max   = 4;
    int stall_max = 4;
    int stall_left = 0;
    int error_count = 0;
    int instr_count = 0;
    int result_count = 0;
    int fault_count = 0;
    int taken_count = 0;

    stack_vm_integer_execute_core dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // ------------------------------------------------------------------------
    // predictor: executes one instruction on the bench copy of the machine
    // ------------------------------------------------------------------------
    function automatic retire_t run_instruction(input logic [4:0] op,
                                                input logic [1:0] rd,
                                                input logic [1:0] rs,
                                                input logic [31:0] imm,
                                                input logic [15:0] tgt);
        retire_t     r;
        logic [15:0] nxt;
        logic [31:0] a;
        logic [31:0] b;
        logic [31:0] d;
        logic        taken;
        fault_t      flt;
        nxt         = vm_pc + 16'd1;
        flt         = FAULT_NONE;
        taken       = 1'b0;
        a           = vm_regs[rd];
        b           = vm_regs[rs];
        r.out_valid = 1'b0;
        r.out_value = '0;
        case (op)
            OP_PUSHC, OP_PUSHR:
            begin
                if (stack_depth >= STACK_SLOTS)
                    flt = FAULT_OVER;
                else
                begin
                    vm_stack[stack_depth] = (op == OP_PUSHC) ? imm : a;
                    stack_depth++;
                end
            end
            OP_MOVRR: vm_regs[rd] = b;
            OP_MOVRC: vm_regs[rd] = imm;
            OP_POPR:
            begin
                if (stack_depth == 0)
                    flt = FAULT_UNDER;
                else
                begin
                    stack_depth--;
                    vm_regs[rd] = vm_stack[stack_depth];
                end
            end
            OP_ADD: vm_regs[rd] = a + b;
            OP_SUB: vm_regs[rd] = a - b;
            OP_MUL: vm_regs[rd] = a * b;
            OP_CMP:
            begin
                // x86 style flags of a - b
                d      = a - b;
                z_flag = (d == 32'd0);
                s_flag = d[31];
                c_flag = (a < b);
                v_flag = (a[31] != b[31]) && (d[31] != a[31]);
            end
            OP_JMP: taken = 1'b1;
            OP_JZ:  taken = z_flag;
            OP_JNZ: taken = !z_flag;
            OP_JG:  taken = !z_flag && (s_flag == v_flag);
            OP_JGE: taken = (s_flag == v_flag);
            OP_JL:  taken = (s_flag != v_flag);
            OP_JLE: taken = z_flag || (s_flag != v_flag);
            OP_OUTINT, OP_OUTCH:
            begin
                if (stack_depth == 0)
                    flt = FAULT_UNDER;
                else
                begin
                    r.out_valid = 1'b1;
                    r.out_value = vm_stack[stack_depth - 1];
                    if (op == OP_OUTCH)
                        r.out_value = {24'd0, r.out_value[7:0]};
                end
            end
            default: ;
        endcase
        if (taken)
        begin
            nxt = tgt;
            taken_count++;
        end
        // a faulting instruction leaves even the pc alone
        if (flt != FAULT_NONE)
        begin
            nxt = vm_pc;
            fault_count++;
        end
        vm_pc     = nxt;
        r.next_pc = nxt;
        r.zero    = z_flag;
        r.sign    = s_flag;
        r.carry   = c_flag;
        r.ovfl    = v_flag;
        r.fault   = flt;
        return r;
    endfunction

    // ------------------------------------------------------------------------
    // sender: one instruction word, with a random idle gap in front
    // ------------------------------------------------------------------------
    task automatic send_instr(input logic [4:0] op, input logic [1:0] rd,
                              input logic [1:0] rs, input logic [31:0] imm,
                              input logic [15:0] tgt);
        int gap;
        gap = (gap_max > 0) ? $urandom_range(0, gap_max) : 0;
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {7'd0, tgt, imm, rs, rd, op};
        do
            @(posedge clk);
        while (!s_tready);
        retire_q.push_back(run_instruction(op, rd, rs, imm, tgt));
        instr_count++;
    endtask

    // hold off the sender until every outstanding result is back
    task automatic wait_results_done();
        s_tvalid <= 1'b0;
        while (retire_q.size() != 0)
            @(posedge clk);
    endtask

    // corner-heavy data word
    function automatic logic [31:0] pick_word();
        case ($urandom_range(0, 7))
            0:       return 32'h0000_0000;
            1:       return 32'h0000_0001;
            2:       return 32'h7FFF_FFFF;
            3:       return 32'h8000_0000;
            4:       return 32'hFFFF_FFFF;
            5:       return 32'h8000_0001;
            default: return $urandom;
        endcase
    endfunction

    // one step of a well-formed program, steered by the current stack depth
    task automatic send_program_step();
        logic [4:0] op;
        int         pick;
        pick = $urandom_range(0, 99);
        if (pick < 20)
            op = (stack_depth > 12) ? OP_POPR
               : ($urandom_range(0, 1) ? OP_PUSHC : OP_PUSHR);
        else if (pick < 30)
            op = (stack_depth == 0) ? OP_PUSHC : OP_POPR;
        else if (pick < 40)
            op = (stack_depth == 0) ? OP_PUSHR
               : ($urandom_range(0, 1) ? OP_OUTINT : OP_OUTCH);
        else if (pick < 52)
            op = OP_MOVRC;
        else if (pick < 57)
            op = OP_MOVRR;
        else if (pick < 72)
            op = 5'(OP_ADD + $urandom_range(0, 2));
        else if (pick < 82)
            op = OP_CMP;
        else
            op = 5'(OP_JMP + $urandom_range(0, 6));
        send_instr(op, 2'($urandom_range(0, 3)), 2'($urandom_range(0, 3)), pick_word(),
                   16'($urandom_range(0, 65535)));
    endtask

    // ------------------------------------------------------------------------
    // receiver: random back-pressure and the result check
    // ------------------------------------------------------------------------
    task automatic check_field(input string what, input logic [31:0] expv,
                               input logic [31:0] actv);
        if (expv !== actv)
        begin
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, what, expv, actv);
            error_count++;
        end
    endtask

    always @(posedge clk)
    begin
        retire_t e;
        int      n;
        if (rst_n)
        begin
            if (stall_left > 0)
            begin
                stall_left--;
                if (stall_left == 0)
                    m_tready <= 1'b1;
            end
            else if (m_tvalid && m_tready)
            begin
                result_count++;
                if (retire_q.size() == 0)
                begin
                    $display("%0t: result word with nothing expected, actual %h", $time,
                             m_tdata);
                    error_count++;
                end
                else
                begin
                    e = retire_q.pop_front();
                    check_field("next_pc", 32'(e.next_pc), 32'(m_tdata[15:0]));
                    check_field("out_valid", 32'(e.out_valid), 32'(m_tdata[16]));
                    check_field("out_value", e.out_value, m_tdata[48:17]);
                    check_field("zero_flag", 32'(e.zero), 32'(m_tdata[49]));
                    check_field("sign_flag", 32'(e.sign), 32'(m_tdata[50]));
                    check_field("carry_flag", 32'(e.carry), 32'(m_tdata[51]));
                    check_field("overflow_flag", 32'(e.ovfl), 32'(m_tdata[52]));
                    check_field("fault", 32'(e.fault), 32'(m_tdata[54:53]));
                end
                n = (stall_max > 0) ? $urandom_range(0, stall_max) : 0;
                if (n > 0)
                begin
                    m_tready   <= 1'b0;
                    stall_left = n;
                end
            end
        end
    end

    // watchdog
    initial
    begin
        repeat (CYCLE_LIMIT) @(posedge clk);
        $display("timeout after %0d cycles, %0d results outstanding", CYCLE_LIMIT,
                 retire_q.size());
        $display("*** FAILED ***");
        $finish;
    end

    // ------------------------------------------------------------------------
    // tests
    // ------------------------------------------------------------------------

    // pop and both outputs on the empty stack right after reset
    task automatic test_empty_stack_faults();
        send_instr(OP_POPR, 2'd3, 2'd0, 32'hFFFF_FFFF, 16'hFFFF);
        send_instr(OP_OUTINT, 2'd0, 2'd3, 32'd0, 16'd0);
        send_instr(OP_OUTCH, 2'd1, 2'd2, 32'hA5A5_5A5A, 16'h5555);
    endtask

    // signed overflow compare, equal compare, each jump once, some taken and some not
    task automatic test_compare_and_jumps();
        send_instr(OP_MOVRC, 2'd0, 2'd0, 32'h8000_0000, 16'd0);
        send_instr(OP_MOVRC, 2'd1, 2'd0, 32'h0000_0001, 16'd0);
        send_instr(OP_CMP, 2'd0, 2'd1, 32'd0, 16'd0);
        send_instr(OP_JL, 2'd0, 2'd0, 32'd0, 16'hFFFF);
        send_instr(OP_JGE, 2'd0, 2'd0, 32'd0, 16'h0000);
        send_instr(OP_CMP, 2'd1, 2'd1, 32'd0, 16'd0);
        send_instr(OP_JZ, 2'd0, 2'd0, 32'd0, 16'h1234);
        send_instr(OP_JNZ, 2'd0, 2'd0, 32'd0, 16'h0040);
        send_instr(OP_JG, 2'd0, 2'd0, 32'd0, 16'h0080);
        send_instr(OP_JLE, 2'd0, 2'd0, 32'd0, 16'hABCD);
        send_instr(OP_JMP, 2'd0, 2'd0, 32'd0, 16'hFFFE);
    endtask

    // all-ones squared, add into the sign bit, subtract that wraps
    task automatic test_arithmetic_wrap();
        send_instr(OP_MOVRC, 2'd2, 2'd0, 32'hFFFF_FFFF, 16'd0);
        send_instr(OP_MUL, 2'd2, 2'd2, 32'd0, 16'd0);
        send_instr(OP_ADD, 2'd2, 2'd0, 32'd0, 16'd0);
        send_instr(OP_SUB, 2'd1, 2'd2, 32'd0, 16'd0);
        send_instr(OP_MOVRR, 2'd3, 2'd1, 32'd0, 16'd0);
    endtask

    // push constant and register, print as char and int, pop back
    task automatic test_stack_output();
        send_instr(OP_PUSHC, 2'd0, 2'd0, 32'hFFFF_FFA5, 16'd0);
        send_instr(OP_PUSHR, 2'd3, 2'd0, 32'd0, 16'd0);
        send_instr(OP_OUTCH, 2'd0, 2'd0, 32'd0, 16'd0);
        send_instr(OP_OUTINT, 2'd0, 2'd0, 32'd0, 16'd0);
        send_instr(OP_POPR, 2'd1, 2'd0, 32'd0, 16'd0);
    endtask

    // codes past the last operation behave as no-ops
    task automatic test_unused_codes();
        send_instr(5'd18, 2'd0, 2'd0, 32'd0, 16'hFFFF);
        send_instr(5'd31, 2'd3, 2'd3, 32'hFFFF_FFFF, 16'hFFFF);
    endtask

    // fill to the top, push past it, empty it, pop past it
    task automatic test_stack_limits(input int rounds);
        repeat (rounds)
        begin
            while (stack_depth < STACK_SLOTS)
                send_instr($urandom_range(0, 1) ? OP_PUSHC : OP_PUSHR,
                           2'($urandom_range(0, 3)), 2'd0, pick_word(),
                           16'($urandom_range(0, 65535)));
            repeat ($urandom_range(1, 3))
                send_instr($urandom_range(0, 1) ? OP_PUSHC : OP_PUSHR,
                           2'($urandom_range(0, 3)), 2'd0, $urandom,
                           16'($urandom_range(0, 65535)));
            send_instr($urandom_range(0, 1) ? OP_OUTINT : OP_OUTCH, 2'd0, 2'd0, 32'd0,
                       16'd0);
            while (stack_depth > 0)
                send_instr(OP_POPR, 2'($urandom_range(0, 3)), 2'($urandom_range(0, 3)),
                           $urandom, 16'($urandom_range(0, 65535)));
            repeat ($urandom_range(1, 2))
                send_instr($urandom_range(0, 1) ? OP_OUTINT : OP_OUTCH, 2'd0, 2'd0, 32'd0,
                           16'd0);
            send_instr(OP_POPR, 2'($urandom_range(0, 3)), 2'd0, 32'd0, 16'd0);
        end
    endtask

    task automatic test_random_programs(input int count);
        repeat (count)
            send_program_step();
    endtask

    // every code and field value, including unused codes
    task automatic test_random_noise(input int count);
        repeat (count)
            send_instr(5'($urandom_range(0, 31)), 2'($urandom_range(0, 3)),
                       2'($urandom_range(0, 3)), $urandom,
                       16'($urandom_range(0, 65535)));
    endtask

    // full rate on both sides
    task automatic test_back_to_back(input int count);
        gap_max   = 0;
        stall_max = 0;
        test_random_programs(count);
        gap_max   = 4;
        stall_max = 4;
    endtask

    initial
    begin
        for (int i = 0; i < NUM_REGS; i++)
            vm_regs[i] = '0;
        for (int i = 0; i < STACK_SLOTS; i++)
            vm_stack[i] = '0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;

        test_empty_stack_faults();
        test_compare_and_jumps();
        test_arithmetic_wrap();
        test_stack_output();
        test_unused_codes();
        wait_results_done();

        test_random_programs(500);
        wait_results_done();
        test_stack_limits(4);
        test_random_noise(300);
        wait_results_done();
        test_back_to_back(150);
        test_random_programs(500);

        wait_results_done();
        repeat (16) @(posedge clk);

        $display("%0d instructions sent, %0d results checked", instr_count, result_count);
        $display("%0d stack faults and %0d taken jumps predicted", fault_count, taken_count);
        if (error_count == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule

`default_nettype wire
